[src/mpow_pkg.sv]
// ----------------------------------------------------------------------------
// mpow_pkg
// Shared types for the modular power core: controller states and the
// control bundle of the serial modular multiplier.
// ----------------------------------------------------------------------------
package mpow_pkg;

   // width of every request and response field
   localparam int FIELD_BITS = 64;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_EU_CHECK,
      ST_EU_DIV_GO,
      ST_EU_DIV_WAIT,
      ST_EU_MUL_GO,
      ST_EU_MUL_WAIT,
      ST_EU_END,
      ST_POW_CHECK,
      ST_POW_GO,
      ST_POW_WAIT
   } state_type;

   // multiplier launch: go pulse and wrapped (no reduction) mode
   typedef struct packed {
      logic go;
      logic wrap;
   } mm_ctl_type;

endpackage

[src/modular_power_core.sv]
// ----------------------------------------------------------------------------
// modular_power_core
// Signed modular exponentiation, base^exponent with floored reduction.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the response shows
// on rsp_* for exactly one cycle under rsp_valid and cannot be held off. A
// zero exponent, or a zero modulus with a negative exponent, answers in the
// next cycle. Otherwise the time is set by two bit-serial multipliers that
// run the multiply and the square of each exponent bit side by side, one
// bit of |exponent| after another, plus a division on the shared divider
// to reduce the base when the modulus is nonzero. A negative exponent adds
// the inverse search: Euclid steps, each a division and a multiply on the
// shared divider and multiplier.
// ----------------------------------------------------------------------------
module modular_power_core
   import mpow_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_BITS-1:0] req_base,
   input  logic [FIELD_BITS-1:0] req_exponent,
   input  logic [FIELD_BITS-1:0] req_modulus,
   output logic                  rsp_valid,
   output logic [FIELD_BITS-1:0] rsp_result,
   output logic                  rsp_no_inverse
);

   localparam int W = WORD_BITS;

   // magnitude of a signed word, most negative value stays exact
   function automatic logic [W-1:0] mag_w(logic [W-1:0] x);
      return x[W-1] ? ('0 - x) : x;
   endfunction

   // floored value of a remainder r given sign of product and of modulus
   function automatic logic [W-1:0] floor_fix(logic neg, logic [W-1:0] r,
                                              logic [W-1:0] n, logic mneg);
      logic [W-1:0] v;
      if (r == '0) begin
         v = '0;
      end else if (!mneg) begin
         v = neg ? (n - r) : r;
      end else begin
         v = neg ? ('0 - r) : (r - n);
      end
      return v;
   endfunction

   state_type state_ff, state_in;

   logic [W-1:0] m_ff, m_in;
   logic [W-1:0] n_ff, n_in;
   logic [W-1:0] cnt_ff, cnt_in;
   logic         e_neg_ff, e_neg_in;
   logic         a_sign_ff, a_sign_in;
   logic [W-1:0] a_mag_ff, a_mag_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] eg_n_ff, eg_n_in;
   logic [W-1:0] eg_av_ff, eg_av_in;
   logic [W-1:0] eg_x_ff, eg_x_in;
   logic [W-1:0] eg_u_ff, eg_u_in;
   logic [W-1:0] eg_q_ff, eg_q_in;
   logic [W-1:0] eg_r_ff, eg_r_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_result_ff, rsp_result_in;
   logic                  rsp_flag_ff, rsp_flag_in;

   // request fields at the core width
   logic         accept;
   logic [W-1:0] base_w;
   logic [W-1:0] exp_w;
   logic [W-1:0] mod_w;
   logic         exp_zero;
   logic         mod_zero;
   logic         wrap;
   logic         m_neg;

   // unit handshakes
   mm_ctl_type   mm0_ctl, mm1_ctl;
   logic [W-1:0] mm0_a, mm0_b, mm1_a, mm1_b;
   logic         mm0_done, mm1_done;
   logic [W-1:0] mm0_prod, mm1_prod;
   logic         div_go;
   logic [W-1:0] div_dvd, div_dsr;
   logic         div_done;
   logic [W-1:0] div_quo, div_rem;

   // finishing
   logic         fin_go;
   logic [W-1:0] fin_result;
   logic         fin_flag;

   // euclid helpers
   logic         eu_bad;
   logic [W-1:0] eu_sub;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign base_w   = req_base[W-1:0];
   assign exp_w    = req_exponent[W-1:0];
   assign mod_w    = req_modulus[W-1:0];
   assign exp_zero = (exp_w == '0);
   assign mod_zero = (mod_w == '0);
   assign wrap     = (m_ff == '0);
   assign m_neg    = m_ff[W-1];
   assign eu_bad   = (eg_n_ff != W'(1)) || (eg_x_ff == '0);
   assign eu_sub   = (eg_x_ff >= mm0_prod) ? (eg_x_ff - mm0_prod)
                                           : (eg_x_ff + (n_ff - mm0_prod));

   // multiply unit and square unit
   mpow_mulmod #(.WORD_BITS(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mm0_ctl),
      .op_a    (mm0_a),
      .op_b    (mm0_b),
      .modulus (n_ff),
      .done    (mm0_done),
      .prod    (mm0_prod)
   );

   mpow_mulmod #(.WORD_BITS(W)) u_sqr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mm1_ctl),
      .op_a    (mm1_a),
      .op_b    (mm1_b),
      .modulus (n_ff),
      .done    (mm1_done),
      .prod    (mm1_prod)
   );

   // shared divider for base reduction and euclid quotients
   mpow_div #(.WORD_BITS(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !exp_zero && !(mod_zero && exp_w[W-1])) begin
               state_in = mod_zero ? ST_POW_CHECK : ST_RED_GO;
            end
         end
         ST_RED_GO: state_in = ST_RED_WAIT;
         ST_RED_WAIT: begin
            if (div_done) begin
               state_in = e_neg_ff ? ST_EU_CHECK : ST_POW_CHECK;
            end
         end
         ST_EU_CHECK: state_in = (eg_av_ff == '0) ? ST_EU_END : ST_EU_DIV_GO;
         ST_EU_DIV_GO: state_in = ST_EU_DIV_WAIT;
         ST_EU_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_EU_MUL_GO;
            end
         end
         ST_EU_MUL_GO: state_in = ST_EU_MUL_WAIT;
         ST_EU_MUL_WAIT: begin
            if (mm0_done) begin
               state_in = ST_EU_CHECK;
            end
         end
         ST_EU_END: state_in = eu_bad ? ST_IDLE : ST_POW_CHECK;
         ST_POW_CHECK: state_in = (cnt_ff == '0) ? ST_IDLE : ST_POW_GO;
         ST_POW_GO: state_in = ST_POW_WAIT;
         ST_POW_WAIT: begin
            if (mm1_done) begin
               state_in = ST_POW_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // unit launches and response
   always_comb begin
      mm0_ctl    = '0;
      mm1_ctl    = '0;
      mm0_a      = a_mag_ff;
      mm0_b      = wrap ? res_ff : mag_w(res_ff);
      mm1_a      = a_mag_ff;
      mm1_b      = a_mag_ff;
      div_go     = 1'b0;
      div_dvd    = a_mag_ff;
      div_dsr    = n_ff;
      fin_go     = 1'b0;
      fin_result = '0;
      fin_flag   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && exp_zero) begin
               fin_go     = 1'b1;
               fin_result = W'(1);
            end else if (accept && mod_zero && exp_w[W-1]) begin
               fin_go = 1'b1;
               if (base_w == W'(1)) begin
                  fin_result = W'(1);
               end else begin
                  fin_flag = 1'b1;
               end
            end
         end
         ST_RED_GO: div_go = 1'b1;
         ST_EU_DIV_GO: begin
            div_go  = 1'b1;
            div_dvd = eg_n_ff;
            div_dsr = eg_av_ff;
         end
         ST_EU_MUL_GO: begin
            mm0_ctl.go = 1'b1;
            mm0_a      = eg_u_ff;
            mm0_b      = eg_q_ff;
         end
         ST_EU_END: begin
            if (eu_bad) begin
               fin_go   = 1'b1;
               fin_flag = 1'b1;
            end
         end
         ST_POW_CHECK: begin
            if (cnt_ff == '0) begin
               fin_go     = 1'b1;
               fin_result = res_ff;
            end
         end
         ST_POW_GO: begin
            mm0_ctl.go   = 1'b1;
            mm0_ctl.wrap = wrap;
            mm1_ctl.go   = 1'b1;
            mm1_ctl.wrap = wrap;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      m_in      = m_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      e_neg_in  = e_neg_ff;
      a_sign_in = a_sign_ff;
      a_mag_in  = a_mag_ff;
      res_in    = res_ff;
      eg_n_in   = eg_n_ff;
      eg_av_in  = eg_av_ff;
      eg_x_in   = eg_x_ff;
      eg_u_in   = eg_u_ff;
      eg_q_in   = eg_q_ff;
      eg_r_in   = eg_r_ff;
      case (state_ff)
         // capture request
         ST_IDLE: begin
            if (accept) begin
               m_in      = mod_w;
               n_in      = mag_w(mod_w);
               cnt_in    = mag_w(exp_w);
               e_neg_in  = exp_w[W-1];
               a_sign_in = base_w[W-1];
               a_mag_in  = mod_zero ? base_w : mag_w(base_w);
               res_in    = W'(1);
            end
         end
         // base reduced modulo |modulus|
         ST_RED_WAIT: begin
            if (div_done) begin
               if (e_neg_ff) begin
                  eg_av_in = (a_sign_ff && div_rem != '0) ? (n_ff - div_rem) : div_rem;
                  eg_n_in  = n_ff;
                  eg_x_in  = '0;
                  eg_u_in  = W'(1);
               end else begin
                  a_mag_in = div_rem;
               end
            end
         end
         ST_EU_DIV_WAIT: begin
            if (div_done) begin
               eg_q_in = div_quo;
               eg_r_in = div_rem;
            end
         end
         // coefficient update kept modulo |modulus|
         ST_EU_MUL_WAIT: begin
            if (mm0_done) begin
               eg_x_in  = eg_u_ff;
               eg_u_in  = eu_sub;
               eg_n_in  = eg_av_ff;
               eg_av_in = eg_r_ff;
            end
         end
         // inverse becomes the new base, floored by the modulus
         ST_EU_END: begin
            a_sign_in = m_neg;
            a_mag_in  = m_neg ? (n_ff - eg_x_ff) : eg_x_ff;
         end
         // one exponent bit: multiply if set, square always
         ST_POW_WAIT: begin
            if (mm1_done) begin
               cnt_in = cnt_ff >> 1;
               if (wrap) begin
                  if (cnt_ff[0]) begin
                     res_in = mm0_prod;
                  end
                  a_mag_in = mm1_prod;
               end else begin
                  if (cnt_ff[0]) begin
                     res_in = floor_fix(res_ff[W-1] ^ a_sign_ff, mm0_prod, n_ff, m_neg);
                  end
                  a_sign_in = m_neg && (mm1_prod != '0);
                  a_mag_in  = (m_neg && mm1_prod != '0) ? (n_ff - mm1_prod) : mm1_prod;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response register inputs
   always_comb begin
      rsp_valid_in  = fin_go;
      rsp_result_in = rsp_result_ff;
      rsp_flag_in   = rsp_flag_ff;
      if (fin_go) begin
         rsp_result_in = FIELD_BITS'($signed(fin_result));
         rsp_flag_in   = fin_flag;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      n_ff          <= n_in;
      cnt_ff        <= cnt_in;
      e_neg_ff      <= e_neg_in;
      a_sign_ff     <= a_sign_in;
      a_mag_ff      <= a_mag_in;
      res_ff        <= res_in;
      eg_n_ff       <= eg_n_in;
      eg_av_ff      <= eg_av_in;
      eg_x_ff       <= eg_x_in;
      eg_u_ff       <= eg_u_in;
      eg_q_ff       <= eg_q_in;
      eg_r_ff       <= eg_r_in;
      rsp_result_ff <= rsp_result_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_result_ff;
   assign rsp_no_inverse = rsp_flag_ff;

endmodule

[src/mpow_mulmod.sv]
// ----------------------------------------------------------------------------
// mpow_mulmod
// Bit-serial interleaved multiplier: prod = op_b * op_a mod modulus, one bit
// of op_b per cycle, MSB first. In wrap mode the product is the low word.
// ----------------------------------------------------------------------------
module mpow_mulmod
   import mpow_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mm_ctl_type           ctl,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   input  logic [WORD_BITS-1:0] modulus,
   output logic                 done,
   output logic [WORD_BITS-1:0] prod
);

   localparam int CW = $clog2(WORD_BITS + 1);
   localparam int TW = WORD_BITS + 2;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 wrap_ff, wrap_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] n_ff, n_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;

   logic [TW-1:0] sum;
   logic [TW-1:0] n1;
   logic [TW-1:0] n2;
   logic [TW-1:0] sub1;
   logic [TW-1:0] sub2;

   // one horner step: double, add, then bring back below the modulus
   always_comb begin
      sum  = {1'b0, acc_ff, 1'b0} + (b_ff[WORD_BITS-1] ? TW'(a_ff) : '0);
      n1   = TW'(n_ff);
      n2   = n1 << 1;
      sub1 = sum - n1;
      sub2 = sum - n2;
   end

   // next values
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      wrap_in = wrap_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      acc_in  = acc_ff;
      if (ctl.go) begin
         run_in  = 1'b1;
         cnt_in  = CW'(WORD_BITS);
         wrap_in = ctl.wrap;
         a_in    = op_a;
         b_in    = op_b;
         n_in    = modulus;
         acc_in  = '0;
      end else if (run_ff) begin
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (wrap_ff) begin
            acc_in = sum[WORD_BITS-1:0];
         end else if (sum >= n2) begin
            acc_in = sub2[WORD_BITS-1:0];
         end else if (sum >= n1) begin
            acc_in = sub1[WORD_BITS-1:0];
         end else begin
            acc_in = sum[WORD_BITS-1:0];
         end
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      wrap_ff <= wrap_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

[src/mpow_div.sv]
// ----------------------------------------------------------------------------
// mpow_div
// Restoring divider, one quotient bit per cycle: quotient and remainder of
// an unsigned word by a nonzero unsigned word.
// ----------------------------------------------------------------------------
module mpow_div
   import mpow_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic                 done,
   output logic [WORD_BITS-1:0] quo,
   output logic [WORD_BITS-1:0] rem
);

   localparam int CW = $clog2(WORD_BITS + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] dvd_ff, dvd_in;
   logic [WORD_BITS-1:0] dsr_ff, dsr_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;

   logic [WORD_BITS:0] trial;
   logic [WORD_BITS:0] diff;
   logic               fits;

   // trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[WORD_BITS-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = !diff[WORD_BITS];
   end

   // next values
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = CW'(WORD_BITS);
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[WORD_BITS-2:0], fits};
         rem_in = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = dvd_ff;
   assign rem  = rem_ff;

endmodule

[src/mpow_checker.sv]
// ----------------------------------------------------------------------------
// mpow_checker
// Port-level checks of the modular power core, bound to the top level.
// ----------------------------------------------------------------------------
module mpow_checker
   import mpow_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [FIELD_BITS-1:0] req_base,
   input logic [FIELD_BITS-1:0] req_exponent,
   input logic [FIELD_BITS-1:0] req_modulus,
   input logic                  rsp_valid,
   input logic [FIELD_BITS-1:0] rsp_result,
   input logic                  rsp_no_inverse
);

   // zero exponent answers 1 in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_exponent[WORD_BITS-1:0] == '0) |=>
         (rsp_valid && rsp_result == FIELD_BITS'(1) && !rsp_no_inverse))
      else $error("zero exponent did not answer 1");

   // a flagged response carries a zero result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_inverse) |-> (rsp_result == '0))
      else $error("no_inverse with nonzero result");

   // the response comes out as the core goes idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // busy only rises on a request
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without start");

endmodule

bind modular_power_core mpow_checker #(.WORD_BITS(WORD_BITS)) u_mpow_checker (.*);
